FILE: rtl/pno_pkg.sv
// shared types, constants and a helper function for the octave noise block
`timescale 1ns / 1ps
`default_nettype none
package pno_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int TBL_AW = $clog2(TABLE_SIZE);
  localparam int MAX_OCTAVES = 16;
  localparam int OCT_W = 5;
  localparam int COORD_FRAC_BITS = 16;

  // low product bits that matter for the scaled coordinate
  localparam int PROD_W = 16 + COORD_FRAC_BITS + 8;
  localparam int PROD_LO = PROD_W / 2;
  localparam int PROD_HI = PROD_W - PROD_LO;

  localparam int FREQ_W = 48;
  localparam int AMP_W = 17;
  localparam int VAL_W = 20;
  localparam int OCTV_W = 21;
  localparam int SUM_W = 40;
  localparam int WGT_W = 21;
  localparam int QUO_W = 17;

  localparam logic [FREQ_W-1:0] FREQ_ONE = FREQ_W'(65536);
  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);

  localparam logic [1:0] CFG_OCTAVES = 2'd0;
  localparam logic [1:0] CFG_LACUNARITY = 2'd1;
  localparam logic [1:0] CFG_GAIN = 2'd2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef struct packed {
    logic        is_load;
    logic [7:0]  entry_index;
    logic [7:0]  entry_value;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
  } pno_cmd_t;

  typedef struct packed {
    logic     valid;
    pno_cmd_t cmd;
  } pno_q_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] addr;
    logic [7:0]        data;
  } pno_ram_wr_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_COORD = 6'b000010,
    ST_TBL   = 6'b000100,
    ST_LERP  = 6'b001000,
    ST_ACC   = 6'b010000,
    ST_DIV   = 6'b100000
  } pno_state_t;

  // gradient dot product picked by the low four hash bits
  function automatic logic signed [VAL_W-1:0] pno_grad(
    input logic [3:0] h,
    input logic signed [VAL_W-1:0] x,
    input logic signed [VAL_W-1:0] y,
    input logic signed [VAL_W-1:0] z
  );
    logic signed [VAL_W-1:0] u;
    logic signed [VAL_W-1:0] v;
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/pno_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module pno_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/pno_front.sv
// front end: takes transactions, classifies them and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none
module pno_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic            in_func,
  input  wire logic [7:0]      in_entry_index,
  input  wire logic [7:0]      in_entry_value,
  input  wire logic [31:0]     in_coord_x,
  input  wire logic [31:0]     in_coord_y,
  input  wire logic [31:0]     in_coord_z,
  output pno_pkg::pno_q_t      q_out,
  input  wire logic            pop
);
  import pno_pkg::*;

  pno_cmd_t   slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic       push;
  pno_cmd_t   cmd_in;

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;

  always_comb begin
    cmd_in.is_load     = (in_func == FUNC_LOAD);
    cmd_in.entry_index = in_entry_index;
    cmd_in.entry_value = in_entry_value;
    cmd_in.coord_x     = in_coord_x;
    cmd_in.coord_y     = in_coord_y;
    cmd_in.coord_z     = in_coord_z;
  end

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  assign q_out.valid = (cnt_r != 2'd0);
  assign q_out.cmd   = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pno_back.sv
// back end: table loads and the octave noise evaluation sequencer
`timescale 1ns / 1ps
`default_nettype none
module pno_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire pno_pkg::pno_q_t              q_in,
  output logic                              pop,
  input  wire logic [pno_pkg::OCT_W-1:0]    n_oct,
  input  wire logic [15:0]                  lacunarity,
  input  wire logic [15:0]                  gain,
  output pno_pkg::pno_ram_wr_t              ram_wr,
  output logic [pno_pkg::TBL_AW-1:0]        ram_raddr,
  input  wire logic [7:0]                   ram_rdata,
  output logic                              out_valid,
  output logic [15:0]                       out_noise_value,
  output logic                              out_was_load
);
  import pno_pkg::*;

  localparam logic [2:0] CS_LAST = 3'd5;
  localparam logic [3:0] TBL_LAST = 4'd14;
  localparam logic [2:0] LS_LAST = 3'd6;
  localparam logic [4:0] DIV_LAST = 5'(QUO_W - 1);

  pno_state_t state_r, state_nxt;

  logic [31:0]        cx_r, cy_r, cz_r;
  logic [FREQ_W-1:0]  freq_r;
  logic [AMP_W-1:0]   amp_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [WGT_W-1:0]   wgt_r;
  logic [OCT_W-1:0]   oct_r;
  logic [2:0]         cs_r;
  logic [PROD_W-1:0]  plo_r;
  logic [7:0]         xc_r, yc_r, zc_r;
  logic [15:0]        xf_r, yf_r, zf_r;
  logic [3:0]         ts_r;
  logic [7:0]         px_r, px1_r, pa_r, pa1_r, pb_r, pb1_r;
  logic [3:0]         haa_r, haa1_r, hab_r, hab1_r, hba_r, hba1_r, hbb_r, hbb1_r;
  logic [31:0]        fm_r;
  logic [15:0]        t3_r;
  logic [19:0]        br_r;
  logic [16:0]        fu_r, fv_r, fw_r;
  logic [2:0]         ls_r;
  logic signed [VAL_W-1:0] l0_r, l1_r, l2_r, l3_r, r0_r, r1_r;
  logic signed [OCTV_W-1:0] o_r;
  logic [WGT_W-1:0]   rem_r;
  logic [QUO_W-1:0]   dq_r;
  logic [4:0]         dc_r;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_noise_r;
  logic               out_was_load_r;

  // scaled coordinate, two partial products per axis
  logic [31:0]          csel;
  logic [PROD_W-1:0]    c_ext;
  logic [PROD_W+PROD_LO-1:0] plo_full;
  logic [2*PROD_HI-1:0] phi_full;
  logic [PROD_W-1:0]    sc;
  logic [7:0]           cell_new;
  logic [15:0]          frac_new;

  always_comb begin
    case (cs_r[2:1])
      2'd0:    csel = cx_r;
      2'd1:    csel = cy_r;
      default: csel = cz_r;
    endcase
    c_ext    = PROD_W'($signed(csel));
    plo_full = c_ext * freq_r[PROD_LO-1:0];
    phi_full = c_ext[PROD_HI-1:0] * freq_r[PROD_W-1:PROD_LO];
    sc       = plo_r + {phi_full[PROD_HI-1:0], {PROD_LO{1'b0}}};
    cell_new = sc[16+COORD_FRAC_BITS+7:16+COORD_FRAC_BITS];
    frac_new = 16'({sc[16+COORD_FRAC_BITS-1:16], 16'b0} >> COORD_FRAC_BITS);
  end

  // table address sequence
  always_comb begin
    case (ts_r)
      4'd0:    ram_raddr = xc_r;
      4'd1:    ram_raddr = xc_r + 8'd1;
      4'd2:    ram_raddr = px_r + yc_r;
      4'd3:    ram_raddr = px_r + yc_r + 8'd1;
      4'd4:    ram_raddr = px1_r + yc_r;
      4'd5:    ram_raddr = px1_r + yc_r + 8'd1;
      4'd6:    ram_raddr = pa_r + zc_r;
      4'd7:    ram_raddr = pa_r + zc_r + 8'd1;
      4'd8:    ram_raddr = pa1_r + zc_r;
      4'd9:    ram_raddr = pa1_r + zc_r + 8'd1;
      4'd10:   ram_raddr = pb_r + zc_r;
      4'd11:   ram_raddr = pb_r + zc_r + 8'd1;
      4'd12:   ram_raddr = pb1_r + zc_r;
      4'd13:   ram_raddr = pb1_r + zc_r + 8'd1;
      default: ram_raddr = xc_r;
    endcase
  end

  // quintic fade, one shared multiplier, three steps per axis
  logic [15:0] ft;
  logic [31:0] fa;
  logic [19:0] fb;
  logic [51:0] fp;
  logic [34:0] six_t2;
  logic [19:0] fifteen_t;
  logic [20:0] br_new;

  always_comb begin
    if (ts_r < 4'd3) begin
      ft = xf_r;
    end else if (ts_r < 4'd6) begin
      ft = yf_r;
    end else begin
      ft = zf_r;
    end
    case (ts_r)
      4'd0, 4'd3, 4'd6: begin
        fa = {16'b0, ft};
        fb = {4'b0, ft};
      end
      4'd1, 4'd4, 4'd7: begin
        fa = fm_r;
        fb = {4'b0, ft};
      end
      default: begin
        fa = {16'b0, t3_r};
        fb = br_r;
      end
    endcase
    fp        = fa * fb;
    six_t2    = {1'b0, fm_r, 2'b0} + {2'b0, fm_r, 1'b0};
    fifteen_t = {ft, 4'b0} - {4'b0, ft};
    br_new    = 21'd655360 + {2'b0, six_t2[34:16]} - {1'b0, fifteen_t};
  end

  // gradients and the shared lerp unit
  logic signed [VAL_W-1:0] gx, gx1, gy, gy1, gz, gz1, gys, gzs;
  logic [3:0]              ha, hb;
  logic signed [VAL_W-1:0] ga, gb, la, lb, lr;
  logic [16:0]             lf;
  logic signed [VAL_W:0]   ld;
  logic signed [38:0]      lp;
  logic signed [OCTV_W-1:0] lr_bias;

  always_comb begin
    gx  = $signed({4'b0, xf_r});
    gy  = $signed({4'b0, yf_r});
    gz  = $signed({4'b0, zf_r});
    gx1 = gx - VAL_W'(65536);
    gy1 = gy - VAL_W'(65536);
    gz1 = gz - VAL_W'(65536);
    gys = ls_r[0] ? gy1 : gy;
    gzs = ls_r[1] ? gz1 : gz;
    case (ls_r[1:0])
      2'd0: begin
        ha = haa_r;
        hb = hba_r;
      end
      2'd1: begin
        ha = hab_r;
        hb = hbb_r;
      end
      2'd2: begin
        ha = haa1_r;
        hb = hba1_r;
      end
      default: begin
        ha = hab1_r;
        hb = hbb1_r;
      end
    endcase
    ga = pno_grad(ha, gx, gys, gzs);
    gb = pno_grad(hb, gx1, gys, gzs);
    case (ls_r)
      3'd4: begin
        lf = fv_r;
        la = l0_r;
        lb = l1_r;
      end
      3'd5: begin
        lf = fv_r;
        la = l2_r;
        lb = l3_r;
      end
      3'd6: begin
        lf = fw_r;
        la = r0_r;
        lb = r1_r;
      end
      default: begin
        lf = fu_r;
        la = ga;
        lb = gb;
      end
    endcase
    ld      = {lb[VAL_W-1], lb} - {la[VAL_W-1], la};
    lp      = $signed({1'b0, lf}) * ld;
    lr      = la + $signed(lp[35:16]);
    lr_bias = ($signed({lr[VAL_W-1], lr}) + OCTV_W'(65536)) >>> 1;
  end

  // octave accumulation
  logic signed [38:0]       ao;
  logic signed [SUM_W-1:0]  sum_acc;
  logic [WGT_W-1:0]         wgt_acc;
  logic [32:0]              ag;
  logic [63:0]              fl;
  logic [OCT_W-1:0]         oct_inc;

  always_comb begin
    ao      = $signed({1'b0, amp_r}) * o_r;
    sum_acc = sum_r + {ao[38], ao};
    wgt_acc = wgt_r + {4'b0, amp_r};
    ag      = amp_r * gain;
    fl      = freq_r * lacunarity;
    oct_inc = oct_r + 5'd1;
  end

  // restoring division step
  logic [WGT_W:0]     rem_sh;
  logic               qbit;
  logic [WGT_W-1:0]   rem_step;
  logic [QUO_W-1:0]   dq_step;

  always_comb begin
    rem_sh   = {rem_r, dq_r[QUO_W-1]};
    qbit     = (rem_sh >= {1'b0, wgt_r});
    rem_step = qbit ? WGT_W'(rem_sh - {1'b0, wgt_r}) : rem_sh[WGT_W-1:0];
    dq_step  = {dq_r[QUO_W-2:0], qbit};
  end

  // control
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    pop           = 1'b0;
    ram_wr.we     = 1'b0;
    ram_wr.addr   = q_in.cmd.entry_index;
    ram_wr.data   = q_in.cmd.entry_value;
    case (state_r)
      ST_IDLE: begin
        if (q_in.valid) begin
          pop = 1'b1;
          if (q_in.cmd.is_load) begin
            ram_wr.we     = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = ST_COORD;
          end
        end
      end
      ST_COORD: begin
        if (cs_r == CS_LAST) begin
          state_nxt = ST_TBL;
        end
      end
      ST_TBL: begin
        if (ts_r == TBL_LAST) begin
          state_nxt = ST_LERP;
        end
      end
      ST_LERP: begin
        if (ls_r == LS_LAST) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (oct_inc >= n_oct) begin
          if (sum_acc < 0) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = ST_DIV;
          end
        end else begin
          state_nxt = ST_COORD;
        end
      end
      ST_DIV: begin
        if (dc_r == 5'd0) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cx_r   <= q_in.cmd.coord_x;
        cy_r   <= q_in.cmd.coord_y;
        cz_r   <= q_in.cmd.coord_z;
        freq_r <= FREQ_ONE;
        amp_r  <= AMP_ONE;
        sum_r  <= '0;
        wgt_r  <= '0;
        oct_r  <= '0;
        cs_r   <= '0;
        out_noise_r    <= 16'd0;
        out_was_load_r <= 1'b1;
      end
      ST_COORD: begin
        if (!cs_r[0]) begin
          plo_r <= plo_full[PROD_W-1:0];
        end else begin
          case (cs_r[2:1])
            2'd0: begin
              xc_r <= cell_new;
              xf_r <= frac_new;
            end
            2'd1: begin
              yc_r <= cell_new;
              yf_r <= frac_new;
            end
            default: begin
              zc_r <= cell_new;
              zf_r <= frac_new;
            end
          endcase
        end
        cs_r <= cs_r + 3'd1;
        ts_r <= '0;
      end
      ST_TBL: begin
        case (ts_r)
          4'd1:    px_r   <= ram_rdata;
          4'd2:    px1_r  <= ram_rdata;
          4'd3:    pa_r   <= ram_rdata;
          4'd4:    pa1_r  <= ram_rdata;
          4'd5:    pb_r   <= ram_rdata;
          4'd6:    pb1_r  <= ram_rdata;
          4'd7:    haa_r  <= ram_rdata[3:0];
          4'd8:    haa1_r <= ram_rdata[3:0];
          4'd9:    hab_r  <= ram_rdata[3:0];
          4'd10:   hab1_r <= ram_rdata[3:0];
          4'd11:   hba_r  <= ram_rdata[3:0];
          4'd12:   hba1_r <= ram_rdata[3:0];
          4'd13:   hbb_r  <= ram_rdata[3:0];
          4'd14:   hbb1_r <= ram_rdata[3:0];
          default: ;
        endcase
        case (ts_r)
          4'd0, 4'd3, 4'd6: fm_r <= fp[31:0];
          4'd1, 4'd4, 4'd7: begin
            t3_r <= fp[47:32];
            br_r <= br_new[19:0];
          end
          4'd2:    fu_r <= fp[32:16];
          4'd5:    fv_r <= fp[32:16];
          4'd8:    fw_r <= fp[32:16];
          default: ;
        endcase
        ts_r <= ts_r + 4'd1;
        ls_r <= '0;
      end
      ST_LERP: begin
        case (ls_r)
          3'd0:    l0_r <= lr;
          3'd1:    l1_r <= lr;
          3'd2:    l2_r <= lr;
          3'd3:    l3_r <= lr;
          3'd4:    r0_r <= lr;
          3'd5:    r1_r <= lr;
          default: o_r  <= lr_bias;
        endcase
        ls_r <= ls_r + 3'd1;
      end
      ST_ACC: begin
        sum_r  <= sum_acc;
        wgt_r  <= wgt_acc;
        amp_r  <= ag[32:16];
        freq_r <= fl[FREQ_W+7:8];
        oct_r  <= oct_inc;
        cs_r   <= '0;
        rem_r  <= sum_acc[QUO_W+WGT_W-1:QUO_W];
        dq_r   <= sum_acc[QUO_W-1:0];
        dc_r   <= DIV_LAST;
        out_noise_r    <= 16'd0;
        out_was_load_r <= 1'b0;
      end
      ST_DIV: begin
        rem_r <= rem_step;
        dq_r  <= dq_step;
        dc_r  <= dc_r - 5'd1;
        out_noise_r    <= dq_step[QUO_W-1] ? 16'hFFFF : dq_step[15:0];
        out_was_load_r <= 1'b0;
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;
  assign out_was_load    = out_was_load_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == ST_IDLE)
    else $error("queue popped while a transaction is in progress");

  a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_was_load_r |-> out_noise_r == 16'd0)
    else $error("load acknowledgement carries a noise value");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_IDLE || state_r == ST_ACC || state_r == ST_DIV))
    else $error("result strobe from an unexpected state");

  a_tbl_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TBL |-> ts_r <= TBL_LAST)
    else $error("table step counter ran past its last step");

  a_div_weight: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> wgt_r >= WGT_W'(AMP_ONE))
    else $error("division entered with a weight below one");

endmodule
`default_nettype wire

FILE: rtl/perlin_noise_3d_octaves.sv
// top level: configuration registers, front end, back end and permutation ram
`timescale 1ns / 1ps
`default_nettype none
// sequence: a load is written to the ram as it leaves the queue and its acknowledgement is registered;
//   an evaluation of n octaves runs 6 coordinate, 15 table, 7 lerp and 1 accumulate steps per octave,
//   then the 17 step division, which a negative sum skips
// throughput: loads one per cycle while the back end is idle; an evaluation holds the single ram read
//   port and the shared fade, lerp and divider units until its result; the receiver cannot stall
// reset: synchronous active low, restores register defaults; the ram is not cleared
module perlin_noise_3d_octaves (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_entry_index,
  input  wire logic [7:0]  in_entry_value,
  input  wire logic [31:0] in_coord_x,
  input  wire logic [31:0] in_coord_y,
  input  wire logic [31:0] in_coord_z,
  output logic             out_valid,
  output logic [15:0]      out_noise_value,
  output logic             out_was_load,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import pno_pkg::*;

  // configuration; the user must write it only while no transaction is in flight, the block does not enforce this
  logic [OCT_W-1:0] octave_count_r;
  logic [15:0]      lacunarity_r;
  logic [15:0]      gain_r;
  logic [OCT_W-1:0] n_oct;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= OCT_W'(1);
      lacunarity_r   <= 16'd512;
      gain_r         <= 16'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OCTAVES:    octave_count_r <= cfg_wdata[OCT_W-1:0];
        CFG_LACUNARITY: lacunarity_r   <= cfg_wdata;
        CFG_GAIN:       gain_r         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // octave count saturates to the range one to the maximum
  always_comb begin
    if (octave_count_r == '0) begin
      n_oct = OCT_W'(1);
    end else if (octave_count_r > OCT_W'(MAX_OCTAVES)) begin
      n_oct = OCT_W'(MAX_OCTAVES);
    end else begin
      n_oct = octave_count_r;
    end
  end

  pno_q_t            q;
  logic              pop;
  pno_ram_wr_t       ram_wr;
  logic [TBL_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // front end queues transactions so the back end can run an evaluation undisturbed
  pno_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .q_out          (q),
    .pop            (pop)
  );

  // permutation table
  pno_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_SIZE)
  ) u_perm (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // back end does table writes and the octave loop, and drives the result strobe
  pno_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_in            (q),
    .pop             (pop),
    .n_oct           (n_oct),
    .lacunarity      (lacunarity_r),
    .gain            (gain_r),
    .ram_wr          (ram_wr),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .out_valid       (out_valid),
    .out_noise_value (out_noise_value),
    .out_was_load    (out_was_load)
  );

endmodule
`default_nettype wire
